FILE: rtl/dteq_pkg.sv
`default_nettype none
package dteq_pkg;
	localparam int INTERNAL_DEPTH_DEF = 64;
	localparam int EXTERNAL_DEPTH_DEF = 32;
	localparam int ENTITY_COUNT_DEF = 16;
	localparam int KIND_MAX_DEF = 3;
	localparam int EXTERNAL_FLAG_BIT_DEF = 15;
	localparam logic [7:0] NOTE_LIMIT = 8'd128;

	localparam int IN_W = 3 + 64 + 3 + 16 + 8 + 8 + 8 + 8 + 64 + 16;
	localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W = 2 + 64 + 3 + 16 + 8 + 8 + 7 + 7 + 16 + 16 + 16 + 16;
	localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

	typedef enum logic [2:0] {
		MODE_PUSH = 3'd0,
		MODE_PEEK = 3'd1,
		MODE_POP = 3'd2,
		MODE_PANIC = 3'd3,
		MODE_FRAMES = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_REJECT = 2'd1,
		ST_EMPTY = 2'd2,
		ST_STAGED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_EXEC
	} bk_state_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [63:0] due_at;
		logic [2:0] kind;
		logic [15:0] trig_code;
		logic [7:0] target;
		logic [7:0] out_port;
		logic [7:0] note;
		logic [7:0] velocity;
		logic last;
		logic [63:0] now_at;
		logic [15:0] frame_cap;
		logic ext;
		logic fields_ok;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [63:0] head_due;
		logic [2:0] head_kind;
		logic [15:0] head_trigger;
		logic [7:0] head_entity;
		logic [7:0] head_output;
		logic [6:0] head_note;
		logic [6:0] head_velocity;
		logic [15:0] pending_count;
		logic [15:0] frames_until;
		logic [15:0] internal_free;
		logic [15:0] external_free;
	} result_t;
endpackage
`default_nettype wire

FILE: rtl/dteq_front.sv
`default_nettype none
module dteq_front import dteq_pkg::*; #(
	parameter int ENTITY_COUNT = ENTITY_COUNT_DEF,
	parameter int KIND_MAX = KIND_MAX_DEF,
	parameter int EXTERNAL_FLAG_BIT = EXTERNAL_FLAG_BIT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [IN_BYTES_W-1:0] in_data,
	input wire logic in_last,
	output logic q_valid,
	input wire logic q_ready,
	output cmd_t q_cmd
);
	// two-entry queue of classified commands
	cmd_t buf_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	cmd_t c;

	always_comb begin
		c.mode = in_data[2:0];
		c.due_at = in_data[66:3];
		c.kind = in_data[69:67];
		c.trig_code = in_data[85:70];
		c.target = in_data[93:86];
		c.out_port = in_data[101:94];
		c.note = in_data[109:102];
		c.velocity = in_data[117:110];
		c.last = in_last;
		c.now_at = in_data[181:118];
		c.frame_cap = in_data[197:182];
		c.ext = c.trig_code[EXTERNAL_FLAG_BIT];
		c.fields_ok = ({1'b0, c.target} < 9'(ENTITY_COUNT))
			&& ({1'b0, c.kind} <= 4'(KIND_MAX)) && (c.out_port != 8'd0)
			&& (c.note < NOTE_LIMIT) && (c.velocity < NOTE_LIMIT);
	end

	assign in_ready = cnt_q != 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign q_cmd = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) buf_q[wr_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wr_q <= ~wr_q;
			if (q_valid && q_ready) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/dteq_back.sv
`default_nettype none
module dteq_back import dteq_pkg::*; #(
	parameter int INTERNAL_DEPTH = INTERNAL_DEPTH_DEF,
	parameter int EXTERNAL_DEPTH = EXTERNAL_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_ready,
	input wire cmd_t q_cmd,
	output logic res_valid,
	input wire logic res_ready,
	output result_t res
);
	localparam int IW = $clog2(INTERNAL_DEPTH);
	localparam int XW = $clog2(EXTERNAL_DEPTH);
	localparam int SW = (IW > XW) ? IW : XW;

	logic [63:0] idue_mem [INTERNAL_DEPTH];
	logic [48:0] iattr_mem [INTERNAL_DEPTH];
	logic [63:0] xdue_mem [EXTERNAL_DEPTH];
	logic [48:0] xattr_mem [EXTERNAL_DEPTH];

	logic [IW-1:0] iwp_q, irp_q;
	logic [XW-1:0] xwp_q, xrp_q;
	logic [SW:0] stg_q;
	logic bopen_q, bfail_q, bext_q, border_q;
	logic [63:0] blast_q;

	bk_state_t state_q, state_d;
	cmd_t cmd_q;
	logic [63:0] idue_rd, xdue_rd, iprev_rd, xprev_rd;
	logic [48:0] iattr_rd, xattr_rd;

	// used and free entry counts per ring queue
	logic [IW:0] iused;
	logic [XW:0] xused;
	logic [IW:0] ifree;
	logic [XW:0] xfree;
	always_comb begin
		iused = (iwp_q >= irp_q) ? {1'b0, iwp_q - irp_q}
			: (IW+1)'(INTERNAL_DEPTH) - {1'b0, irp_q} + {1'b0, iwp_q};
		xused = (xwp_q >= xrp_q) ? {1'b0, xwp_q - xrp_q}
			: (XW+1)'(EXTERNAL_DEPTH) - {1'b0, xrp_q} + {1'b0, xwp_q};
		ifree = (IW+1)'(INTERNAL_DEPTH - 1) - iused;
		xfree = (XW+1)'(EXTERNAL_DEPTH - 1) - xused;
	end

	function automatic logic [IW-1:0] iwrap(input logic [IW:0] s);
		return (s >= (IW+1)'(INTERNAL_DEPTH)) ? IW'(s - (IW+1)'(INTERNAL_DEPTH)) : IW'(s);
	endfunction
	function automatic logic [XW-1:0] xwrap(input logic [XW:0] s);
		return (s >= (XW+1)'(EXTERNAL_DEPTH)) ? XW'(s - (XW+1)'(EXTERNAL_DEPTH)) : XW'(s);
	endfunction

	logic [IW-1:0] iprev;
	logic [XW-1:0] xprev;
	assign iprev = (iwp_q == '0) ? IW'(INTERNAL_DEPTH - 1) : iwp_q - 1'b1;
	assign xprev = (xwp_q == '0) ? XW'(EXTERNAL_DEPTH - 1) : xwp_q - 1'b1;

	// read cycle: heads and newest committed entries
	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && q_valid) begin
			cmd_q <= q_cmd;
		end
		if (state_q == BK_READ) begin
			idue_rd <= idue_mem[irp_q];
			iattr_rd <= iattr_mem[irp_q];
			xdue_rd <= xdue_mem[xrp_q];
			xattr_rd <= xattr_mem[xrp_q];
			iprev_rd <= idue_mem[iprev];
			xprev_rd <= xdue_mem[xprev];
		end
	end

	// execute cycle combinational decisions
	logic hi, hx, pick_x, any_h, open_now, ext_b, order_b, bad;
	logic [63:0] last_b, hdue;
	logic [48:0] hattr;
	logic [SW:0] stg_b, free_b;
	logic [IW-1:0] islot;
	logic [XW-1:0] xslot;
	logic [63:0] diff;
	logic [15:0] fr;
	always_comb begin
		hi = iwp_q != irp_q;
		hx = xwp_q != xrp_q;
		any_h = hi || hx;
		if (!hx) pick_x = 1'b0;
		else if (!hi) pick_x = 1'b1;
		else if (idue_rd != xdue_rd) pick_x = !(idue_rd < xdue_rd);
		else pick_x = !(iattr_rd[2:0] <= xattr_rd[2:0]);
		hdue = pick_x ? xdue_rd : idue_rd;
		hattr = pick_x ? xattr_rd : iattr_rd;

		open_now = !bopen_q;
		ext_b = open_now ? cmd_q.ext : bext_q;
		stg_b = open_now ? '0 : stg_q;
		if (open_now) begin
			order_b = cmd_q.ext ? hx : hi;
			last_b = order_b ? (cmd_q.ext ? xprev_rd : iprev_rd) : 64'd0;
		end else begin
			order_b = border_q;
			last_b = blast_q;
		end
		free_b = ext_b ? (SW+1)'(xfree) : (SW+1)'(ifree);
		bad = !cmd_q.fields_ok || (cmd_q.ext != ext_b)
			|| (order_b && cmd_q.due_at < last_b) || (stg_b >= free_b);
		islot = iwrap((IW+1)'(iwp_q) + (IW+1)'(stg_b));
		xslot = xwrap((XW+1)'(xwp_q) + (XW+1)'(stg_b));

		// clamp applies only when some head exists
		diff = hdue - cmd_q.now_at;
		fr = cmd_q.frame_cap;
		if (any_h && cmd_q.frame_cap != 16'd0) begin
			if (hdue <= cmd_q.now_at) fr = 16'd0;
			else if (diff < {48'd0, cmd_q.frame_cap}) fr = diff[15:0];
		end
	end

	// store writes for every push that passes its own checks
	always_ff @(posedge clk) begin
		if (state_q == BK_EXEC && cmd_q.mode == MODE_PUSH && !bad) begin
			if (ext_b) begin
				xdue_mem[xslot] <= cmd_q.due_at;
				xattr_mem[xslot] <= {cmd_q.velocity[6:0], cmd_q.note[6:0],
					cmd_q.out_port, cmd_q.target, cmd_q.trig_code, cmd_q.kind};
			end else begin
				idue_mem[islot] <= cmd_q.due_at;
				iattr_mem[islot] <= {cmd_q.velocity[6:0], cmd_q.note[6:0],
					cmd_q.out_port, cmd_q.target, cmd_q.trig_code, cmd_q.kind};
			end
		end
	end

	always_comb begin
		state_d = state_q;
		q_ready = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				q_ready = !res_valid || res_ready;
				if (q_valid && q_ready) state_d = BK_READ;
			end
			BK_READ: state_d = BK_EXEC;
			BK_EXEC: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// pointer and batch update, result capture
	logic [IW-1:0] iwp_n, irp_n;
	logic [XW-1:0] xwp_n, xrp_n;
	logic [1:0] st;
	logic [IW:0] iused_n;
	logic [XW:0] xused_n;
	always_comb begin
		iwp_n = iwp_q; irp_n = irp_q; xwp_n = xwp_q; xrp_n = xrp_q;
		st = ST_REJECT;
		unique case (cmd_q.mode)
			MODE_PUSH: begin
				if (cmd_q.last) begin
					if (bfail_q && !open_now || bad) st = ST_REJECT;
					else begin
						st = ST_OK;
						if (ext_b) xwp_n = xwrap((XW+1)'(xwp_q) + (XW+1)'(stg_b + 1'b1));
						else iwp_n = iwrap((IW+1)'(iwp_q) + (IW+1)'(stg_b + 1'b1));
					end
				end else begin
					st = ((bfail_q && !open_now) || bad) ? ST_REJECT : ST_STAGED;
				end
			end
			MODE_PEEK: st = any_h ? ST_OK : ST_EMPTY;
			MODE_POP: begin
				if (cmd_q.ext ? !hx : !hi) st = ST_EMPTY;
				else begin
					st = ST_OK;
					if (cmd_q.ext) xrp_n = xwrap((XW+1)'(xrp_q) + 1'b1);
					else irp_n = iwrap((IW+1)'(irp_q) + 1'b1);
				end
			end
			MODE_PANIC: begin
				st = ST_OK; irp_n = iwp_q; xrp_n = xwp_q;
			end
			MODE_FRAMES: st = any_h ? ST_OK : ST_EMPTY;
			default: st = ST_REJECT;
		endcase
		iused_n = (iwp_n >= irp_n) ? {1'b0, iwp_n - irp_n}
			: (IW+1)'(INTERNAL_DEPTH) - {1'b0, irp_n} + {1'b0, iwp_n};
		xused_n = (xwp_n >= xrp_n) ? {1'b0, xwp_n - xrp_n}
			: (XW+1)'(EXTERNAL_DEPTH) - {1'b0, xrp_n} + {1'b0, xwp_n};
	end

	result_t res_d;
	always_comb begin
		res_d = '0;
		res_d.status = st;
		if (cmd_q.mode == MODE_PEEK && any_h) begin
			res_d.head_due = hdue;
			res_d.head_kind = hattr[2:0];
			res_d.head_trigger = hattr[18:3];
			res_d.head_entity = hattr[26:19];
			res_d.head_output = hattr[34:27];
			res_d.head_note = hattr[41:35];
			res_d.head_velocity = hattr[48:42];
		end
		if (cmd_q.mode == MODE_FRAMES) res_d.frames_until = fr;
		res_d.pending_count = 16'(iused_n) + 16'(xused_n);
		res_d.internal_free = 16'((IW+1)'(INTERNAL_DEPTH - 1) - iused_n);
		res_d.external_free = 16'((XW+1)'(EXTERNAL_DEPTH - 1) - xused_n);
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_EXEC) res <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			res_valid <= 1'b0;
			iwp_q <= '0; irp_q <= '0; xwp_q <= '0; xrp_q <= '0;
			stg_q <= '0; bopen_q <= 1'b0; bfail_q <= 1'b0; bext_q <= 1'b0;
			border_q <= 1'b0; blast_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_EXEC) res_valid <= 1'b1;
			else if (res_valid && res_ready) res_valid <= 1'b0;
			if (state_q == BK_EXEC) begin
				iwp_q <= iwp_n; irp_q <= irp_n; xwp_q <= xwp_n; xrp_q <= xrp_n;
				if (cmd_q.mode == MODE_PUSH) begin
					if (cmd_q.last) begin
						bopen_q <= 1'b0; bfail_q <= 1'b0; stg_q <= '0;
						border_q <= 1'b0; blast_q <= '0;
					end else begin
						bopen_q <= 1'b1;
						bext_q <= ext_b;
						bfail_q <= (bfail_q && !open_now) || bad;
						stg_q <= bad ? stg_b : stg_b + 1'b1;
						border_q <= bad ? order_b : 1'b1;
						blast_q <= bad ? last_b : cmd_q.due_at;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/dual_timestamp_event_queue.sv
`default_nettype none
// channel   dir  tdata fields (low bit up)                                    tlast  tuser
// s_axis    in   mode, due_at, kind, trig_code, target, out_port,             last   -
//                note, velocity, now_at, frame_cap
// m_axis    out  status, head_due, head_kind, head_trigger, head_entity,      -      -
//                head_output, head_note, head_velocity, pending_count,
//                frames_until, internal_free, external_free
// each item passes the back-end states in order: take, store read, execute, and a new
// item is taken only once the last one has executed; the ring queue store read is registered
// a two-entry command queue lets the front accept up to two commands while the back stalls
// reset clears pointers and batch state; store contents are undefined until written
module dual_timestamp_event_queue import dteq_pkg::*; #(
	parameter int INTERNAL_DEPTH = INTERNAL_DEPTH_DEF,
	parameter int EXTERNAL_DEPTH = EXTERNAL_DEPTH_DEF,
	parameter int ENTITY_COUNT = ENTITY_COUNT_DEF,
	parameter int KIND_MAX = KIND_MAX_DEF,
	parameter int EXTERNAL_FLAG_BIT = EXTERNAL_FLAG_BIT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// mode, due_at, kind, trig_code, target, out_port, note, velocity, now_at, frame_cap
	input wire logic [IN_BYTES_W-1:0] s_axis_tdata,
	input wire logic s_axis_tlast, // last item of a push batch
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// status, head_due, head_kind, head_trigger, head_entity, head_output, head_note,
	// head_velocity, pending_count, frames_until, internal_free, external_free
	output logic [OUT_BYTES_W-1:0] m_axis_tdata
);
	logic q_valid, q_ready;
	cmd_t q_cmd;
	result_t res;

	// front: unpack, classify field checks and queue choice
	dteq_front #(
		.ENTITY_COUNT(ENTITY_COUNT),
		.KIND_MAX(KIND_MAX),
		.EXTERNAL_FLAG_BIT(EXTERNAL_FLAG_BIT)
	) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data(s_axis_tdata), .in_last(s_axis_tlast),
		.q_valid, .q_ready, .q_cmd
	);

	// back: ring queues, batch staging, head merge
	dteq_back #(
		.INTERNAL_DEPTH(INTERNAL_DEPTH),
		.EXTERNAL_DEPTH(EXTERNAL_DEPTH)
	) u_back (
		.clk, .arst_n,
		.q_valid, .q_ready, .q_cmd,
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
	);

	// result fields, status in the lowest bits
	assign m_axis_tdata = OUT_BYTES_W'({res.external_free, res.internal_free,
		res.frames_until, res.pending_count, res.head_velocity, res.head_note,
		res.head_output, res.head_entity, res.head_trigger, res.head_kind,
		res.head_due, res.status});
endmodule
`default_nettype wire
